// File: rtl/aoc_pkg.sv
// Shared types, widths and helpers for the accelerometer offset calibration block.
// No dependencies; every other file imports this package.
package aoc_pkg;

    localparam int RAW_W     = 16;   // raw axis word
    localparam int SMP_W     = 12;   // scaled sample, -2048..2047
    localparam int OUT_W     = 14;   // result field
    localparam int ONE_G_W   = 11;   // one_g register
    localparam int SUM_W     = 20;   // per-axis quotient / offset
    localparam int REC_SHIFT = 20;   // fraction bits of the reciprocal
    localparam int AXES      = 3;
    localparam int AXIS_Z    = 2;

    localparam int DEF_CALIB_SAMPLES = 100;

    localparam logic [ONE_G_W-1:0] ONE_G_RST = 11'd255;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index taken from paddr above the byte offset
    typedef enum logic [0:0] {
        REG_ONE_G = 1'b0
    } t_reg_idx;

    typedef logic signed [SMP_W-1:0] t_smp;

    // Load enables for the three pipeline registers, plus the state update strobe
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic upd;
    } t_stage_ctl;

    // Read a raw word as two's complement and divide by 16, truncating toward zero
    function automatic t_smp scale_word(input logic [RAW_W-1:0] w);
        logic signed [RAW_W-1:0] v;
        logic [SMP_W-1:0]        q;
        v = signed'(w);
        q = SMP_W'(v >>> 4);
        if (v[RAW_W-1] && (w[3:0] != 4'd0)) begin
            q = q + SMP_W'(1);
        end
        return t_smp'(q);
    endfunction

endpackage

// File: rtl/aoc_regs.sv
// APB-style configuration register file for the offset calibration block.
// Depends on aoc_pkg for widths, register index codes and the one_g reset value.
module aoc_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [aoc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [aoc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [aoc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [aoc_pkg::ONE_G_W-1:0]     o_one_g
);
    import aoc_pkg::*;

    logic [ONE_G_W-1:0] r_one_g;
    logic [ONE_G_W-1:0] n_one_g;
    t_reg_idx           reg_idx;
    logic               wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Decode writes and reads; unknown indexes write nothing and read zero
    always_comb begin
        n_one_g = r_one_g;
        prdata  = '0;
        unique case (reg_idx)
            REG_ONE_G: begin
                prdata = APB_DATA_W'(r_one_g);
                if (wr_en) begin
                    n_one_g = pwdata[ONE_G_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_g <= ONE_G_RST;
        end else begin
            r_one_g <= n_one_g;
        end
    end

    assign o_one_g = r_one_g;

endmodule

// File: rtl/aoc_prescale.sv
// Input register and scaling stage: scales each axis word and forms the
// reciprocal product used to split the sample into quotient and remainder.
// Depends on aoc_pkg for widths, the stage control struct and scale_word.
module aoc_prescale #(
    parameter int CALIB_SAMPLES = aoc_pkg::DEF_CALIB_SAMPLES
) (
    input  logic                        i_clk,
    input  aoc_pkg::t_stage_ctl         i_ctl,
    input  logic                        i_cmd,
    input  logic [aoc_pkg::RAW_W-1:0]   i_raw_x,
    input  logic [aoc_pkg::RAW_W-1:0]   i_raw_y,
    input  logic [aoc_pkg::RAW_W-1:0]   i_raw_z,
    output logic                        o_cmd,
    output aoc_pkg::t_smp               o_smp [aoc_pkg::AXES],
    output logic [aoc_pkg::SMP_W-1:0]   o_u   [aoc_pkg::AXES],
    output logic [aoc_pkg::SMP_W-1:0]   o_uq  [aoc_pkg::AXES]
);
    import aoc_pkg::*;

    localparam int PROD_W = SMP_W + REC_SHIFT;
    // Rounded-up reciprocal; exact floor for every 12-bit dividend up to 4095 with the default CALIB_SAMPLES
    localparam logic [REC_SHIFT-1:0] RECIP =
        REC_SHIFT'((2**REC_SHIFT + CALIB_SAMPLES - 1) / CALIB_SAMPLES);

    logic             r_cmd1;
    logic [RAW_W-1:0] r_raw1 [AXES];
    logic             r_cmd2;
    t_smp             r_smp2 [AXES];
    logic [SMP_W-1:0] r_u2   [AXES];
    logic [SMP_W-1:0] r_uq2  [AXES];

    t_smp             n_smp  [AXES];
    logic [SMP_W-1:0] n_u    [AXES];
    logic [SMP_W-1:0] n_uq   [AXES];
    logic [PROD_W-1:0] prod  [AXES];

    // Scale, bias to unsigned (add 2048 by flipping the sign bit), multiply
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_smp[a] = scale_word(r_raw1[a]);
            n_u[a]   = {~n_smp[a][SMP_W-1], n_smp[a][SMP_W-2:0]};
            prod[a]  = PROD_W'(n_u[a]) * PROD_W'(RECIP);
            n_uq[a]  = prod[a][REC_SHIFT +: SMP_W];
        end
    end

    // Capture the incoming transaction
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_cmd1    <= i_cmd;
            r_raw1[0] <= i_raw_x;
            r_raw1[1] <= i_raw_y;
            r_raw1[2] <= i_raw_z;
        end
    end

    // Hold the scaled sample and its biased quotient
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_cmd2 <= r_cmd1;
            for (int a = 0; a < AXES; a++) begin
                r_smp2[a] <= n_smp[a];
                r_u2[a]   <= n_u[a];
                r_uq2[a]  <= n_uq[a];
            end
        end
    end

    assign o_cmd = r_cmd2;
    assign o_smp = r_smp2;
    assign o_u   = r_u2;
    assign o_uq  = r_uq2;

endmodule

// File: rtl/aoc_calib.sv
// Calibration state and result register: accumulates each axis as a running
// quotient and remainder of the sum by CALIB_SAMPLES, then applies offsets.
// Depends on aoc_pkg for widths and the stage control struct.
module aoc_calib #(
    parameter int CALIB_SAMPLES = aoc_pkg::DEF_CALIB_SAMPLES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  aoc_pkg::t_stage_ctl             i_ctl,
    input  logic                            i_cmd,
    input  aoc_pkg::t_smp                   i_smp [aoc_pkg::AXES],
    input  logic [aoc_pkg::SMP_W-1:0]       i_u   [aoc_pkg::AXES],
    input  logic [aoc_pkg::SMP_W-1:0]       i_uq  [aoc_pkg::AXES],
    input  logic [aoc_pkg::ONE_G_W-1:0]     i_one_g,
    output logic signed [aoc_pkg::OUT_W-1:0] o_out [aoc_pkg::AXES],
    output logic                            o_calibrated
);
    import aoc_pkg::*;

    localparam int CW   = $clog2(CALIB_SAMPLES + 1);
    localparam int RW   = $clog2(CALIB_SAMPLES);
    localparam int Bias = 2**(SMP_W - 1);
    localparam int BIAS_Q = Bias / CALIB_SAMPLES;
    localparam int BIAS_R = Bias % CALIB_SAMPLES;

    localparam logic [CW-1:0] CNT_LOAD = CW'(CALIB_SAMPLES);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_ZERO = '0;

    // Running floor quotient and remainder of each axis sum
    logic [CW-1:0]            r_cnt;
    logic signed [SUM_W-1:0]  r_q   [AXES];
    logic [RW-1:0]            r_r   [AXES];
    logic signed [OUT_W-1:0]  r_out [AXES];
    logic                     r_cal;

    logic [CW-1:0]            n_cnt;
    logic signed [SUM_W-1:0]  n_q   [AXES];
    logic [RW-1:0]            n_r   [AXES];
    logic signed [OUT_W-1:0]  n_out [AXES];
    logic                     n_cal;

    logic [SMP_W-1:0]         ur    [AXES];
    logic signed [RW+1:0]     rs    [AXES];
    logic signed [SMP_W:0]    qs    [AXES];
    logic [RW:0]              rsum  [AXES];
    logic                     carry [AXES];
    logic signed [SUM_W-1:0]  q_acc [AXES];
    logic signed [SUM_W-1:0]  q_fin [AXES];
    logic signed [SUM_W-1:0]  corr  [AXES];

    // Split each sample into floor quotient and remainder, fold into the sums
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            ur[a] = i_u[a] - SMP_W'(i_uq[a] * SMP_W'(CALIB_SAMPLES));
            rs[a] = signed'({2'b00, ur[a][RW-1:0]}) - (RW+2)'(BIAS_R);
            qs[a] = signed'({1'b0, i_uq[a]}) - (SMP_W+1)'(BIAS_Q);
            // remove the bias: borrow one quotient step when the remainder goes negative
            if (rs[a] < 0) begin
                rs[a] = rs[a] + (RW+2)'(CALIB_SAMPLES);
                qs[a] = qs[a] - (SMP_W+1)'(1);
            end
            rsum[a]  = (RW+1)'(r_r[a]) + (RW+1)'(rs[a][RW-1:0]);
            carry[a] = (rsum[a] >= (RW+1)'(CALIB_SAMPLES));
            if (carry[a]) begin
                rsum[a] = rsum[a] - (RW+1)'(CALIB_SAMPLES);
            end
            q_acc[a] = r_q[a] + SUM_W'(qs[a]) + signed'(SUM_W'(carry[a]));
            // turn floor into truncation toward zero for a negative sum
            q_fin[a] = r_q[a] + signed'(SUM_W'((r_q[a] < 0) && (r_r[a] != '0)));
            corr[a]  = SUM_W'(i_smp[a]) - r_q[a];
        end
        q_fin[AXIS_Z] = q_fin[AXIS_Z] - signed'(SUM_W'(i_one_g));
    end

    // Advance the countdown and choose the result
    always_comb begin
        n_cnt = r_cnt;
        n_cal = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            n_q[a]   = r_q[a];
            n_r[a]   = r_r[a];
            n_out[a] = OUT_W'(i_smp[a]);
        end
        if (i_cmd) begin
            n_cnt = CNT_LOAD;
            for (int a = 0; a < AXES; a++) begin
                n_q[a] = '0;
                n_r[a] = '0;
            end
        end else if (r_cnt == CNT_ONE) begin
            n_cnt = CNT_ZERO;
            for (int a = 0; a < AXES; a++) begin
                n_q[a] = q_fin[a];
            end
        end else if (r_cnt != CNT_ZERO) begin
            n_cnt = r_cnt - CNT_ONE;
            for (int a = 0; a < AXES; a++) begin
                n_q[a] = q_acc[a];
                n_r[a] = rsum[a][RW-1:0];
            end
        end else begin
            n_cal = 1'b1;
            for (int a = 0; a < AXES; a++) begin
                n_out[a] = corr[a][OUT_W-1:0];
            end
        end
    end

    // Update calibration state once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_ZERO;
            for (int a = 0; a < AXES; a++) begin
                r_q[a] <= '0;
                r_r[a] <= '0;
            end
        end else if (i_ctl.upd) begin
            r_cnt <= n_cnt;
            r_q   <= n_q;
            r_r   <= n_r;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_out <= n_out;
            r_cal <= n_cal;
        end
    end

    assign o_out        = r_out;
    assign o_calibrated = r_cal;

endmodule

// File: rtl/accel_offset_calibration.sv
// Accelerometer offset calibration: takes one three-axis sample per cycle when not
// stalled and passes it through three registers (input register, scaling register,
// result register). Throughput is one transaction per clock when the output does not
// stall, set by the three-register pipeline; an output stall backs up only as far as
// the first empty stage. Each raw word is read as two's complement and divided
// by 16. A transaction with cmd set restarts calibration: the next
// CALIB_SAMPLES-1 samples are summed per axis and passed out uncorrected, the
// one after that turns the sums into offsets (one_g removed from z), and from
// then on the offsets are subtracted and calibrated reads 1. No clearing pass
// is needed after reset; one_g sits at byte address 0 of the APB port.
// Depends on aoc_pkg, aoc_regs, aoc_prescale and aoc_calib.
module accel_offset_calibration #(
    parameter int CALIB_SAMPLES = aoc_pkg::DEF_CALIB_SAMPLES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // sample input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_cmd,
    input  logic [aoc_pkg::RAW_W-1:0]        i_raw_x,
    input  logic [aoc_pkg::RAW_W-1:0]        i_raw_y,
    input  logic [aoc_pkg::RAW_W-1:0]        i_raw_z,
    // result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [aoc_pkg::OUT_W-1:0] o_out_x,
    output logic signed [aoc_pkg::OUT_W-1:0] o_out_y,
    output logic signed [aoc_pkg::OUT_W-1:0] o_out_z,
    output logic                             o_calibrated,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [aoc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [aoc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [aoc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import aoc_pkg::*;

    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               en1;
    logic               en2;
    logic               en3;
    t_stage_ctl         ctl;

    logic [ONE_G_W-1:0] one_g;
    logic               cmd2;
    t_smp               smp2 [AXES];
    logic [SMP_W-1:0]   u2   [AXES];
    logic [SMP_W-1:0]   uq2  [AXES];
    logic signed [OUT_W-1:0] res [AXES];

    // Advance each stage when the one after it is empty or moving
    assign en3 = !r_v3 || !i_stall;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign ctl.ld1 = en1;
    assign ctl.ld2 = en2;
    assign ctl.ld3 = en3;
    assign ctl.upd = en3 && r_v2;

    assign o_stall = !en1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    aoc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_one_g (one_g)
    );

    aoc_prescale #(
        .CALIB_SAMPLES (CALIB_SAMPLES)
    ) u_prescale (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_cmd   (i_cmd),
        .i_raw_x (i_raw_x),
        .i_raw_y (i_raw_y),
        .i_raw_z (i_raw_z),
        .o_cmd   (cmd2),
        .o_smp   (smp2),
        .o_u     (u2),
        .o_uq    (uq2)
    );

    aoc_calib #(
        .CALIB_SAMPLES (CALIB_SAMPLES)
    ) u_calib (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_cmd        (cmd2),
        .i_smp        (smp2),
        .i_u          (u2),
        .i_uq         (uq2),
        .i_one_g      (one_g),
        .o_out        (res),
        .o_calibrated (o_calibrated)
    );

    assign o_out_x = res[0];
    assign o_out_y = res[1];
    assign o_out_z = res[2];

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for accel_offset_calibration: drives raw three-axis samples and
// restarts, predicts each reading with its own calibration model and compares every result.
// Depends on aoc_pkg and the accel_offset_calibration RTL.
module tb_top;

    import aoc_pkg::*;

    localparam int N_CAL       = DEF_CALIB_SAMPLES;
    localparam int ITEM_TARGET = 750;
    localparam logic [APB_ADDR_W-1:0] ONE_G_ADDR = APB_ADDR_W'(4 * int'(REG_ONE_G));
    // first address past the last register, must be ignored by the block
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = APB_ADDR_W'(4 * (int'(REG_ONE_G) + 1));

    typedef struct packed {
        logic             cmd;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
        logic [RAW_W-1:0] raw_z;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_x;
        logic signed [OUT_W-1:0] out_y;
        logic signed [OUT_W-1:0] out_z;
        logic                    calibrated;
    } reading_t;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic                    i_cmd   = 1'b0;
    logic [RAW_W-1:0]        i_raw_x = '0;
    logic [RAW_W-1:0]        i_raw_y = '0;
    logic [RAW_W-1:0]        i_raw_z = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [OUT_W-1:0] o_out_x;
    logic signed [OUT_W-1:0] o_out_y;
    logic signed [OUT_W-1:0] o_out_z;
    logic                    o_calibrated;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr   = '0;
    logic [APB_DATA_W-1:0]   pwdata  = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // predictor state: countdown, per-axis sums (offsets once calibrated), one_g
    logic [6:0]           cal_count = '0;
    int                   axis_acc [3] = '{0, 0, 0};
    logic [ONE_G_W-1:0]   one_g_val = ONE_G_RST;

    sample_t  sample_queue[$];
    reading_t pending_readings[$];
    sample_t  cur_sample;

    int items_queued    = 0;
    int restarts_queued = 0;
    int items_sent      = 0;
    int results_seen    = 0;
    int calibrated_seen = 0;
    int settings_used   = 1;
    int mismatch_count  = 0;
    int hold_left       = 0;
    int next_hold_at    = 200;

    accel_offset_calibration #(.CALIB_SAMPLES(N_CAL)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_raw_x     (i_raw_x),
        .i_raw_y     (i_raw_y),
        .i_raw_z     (i_raw_z),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_calibrated(o_calibrated),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Two's complement word divided by 16, truncating toward zero
    function automatic int scale_raw(logic [RAW_W-1:0] raw);
        logic signed [RAW_W-1:0] w;
        int v;
        w = raw;
        v = w;
        return v / 16;
    endfunction

    // Advance the calibration state by one sample and return the expected reading
    function automatic reading_t calibrate_sample(sample_t s);
        int       scaled [3];
        reading_t r;
        int       k;
        scaled[0] = scale_raw(s.raw_x);
        scaled[1] = scale_raw(s.raw_y);
        scaled[2] = scale_raw(s.raw_z);
        r.calibrated = 1'b0;
        if (s.cmd) begin
            cal_count = 7'(N_CAL);
            axis_acc  = '{0, 0, 0};
        end else if (cal_count != 0) begin
            if (cal_count == 7'd1) begin
                // sums become offsets; z also loses one g
                for (k = 0; k < AXES; k++) begin
                    axis_acc[k] = axis_acc[k] / N_CAL;
                end
                axis_acc[AXIS_Z] -= int'(one_g_val);
            end else begin
                for (k = 0; k < AXES; k++) begin
                    axis_acc[k] += scaled[k];
                end
            end
            cal_count = cal_count - 7'd1;
        end else begin
            for (k = 0; k < AXES; k++) begin
                scaled[k] -= axis_acc[k];
            end
            r.calibrated = 1'b1;
        end
        r.out_x = OUT_W'(scaled[0]);
        r.out_y = OUT_W'(scaled[1]);
        r.out_z = OUT_W'(scaled[2]);
        return r;
    endfunction

    // Mostly values near a bias, some full-range words and some extremes
    function automatic logic [RAW_W-1:0] random_axis(int bias);
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 12) begin
            case ($urandom_range(5))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                3: return 16'hFFFF;
                4: return 16'hFFF0;
                default: return 16'h000F;
            endcase
        end
        if (pick < 35) begin
            return RAW_W'($urandom);
        end
        v = bias + int'($urandom_range(64)) - 32;
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return {12'(v), 4'($urandom)};
    endfunction

    task automatic queue_sample(logic cmd, logic [RAW_W-1:0] x, logic [RAW_W-1:0] y,
                                logic [RAW_W-1:0] z);
        sample_t s;
        s.cmd   = cmd;
        s.raw_x = x;
        s.raw_y = y;
        s.raw_z = z;
        sample_queue.push_back(s);
        items_queued++;
        if (cmd) restarts_queued++;
    endtask

    // Restart, then a full countdown of samples, then a tail of samples with occasional restarts.
    // A broken run gets one extra restart somewhere inside the countdown.
    task automatic queue_calibration(logic [RAW_W-1:0] fixed_word, bit use_fixed, int tail,
                                     bit broken);
        int left;
        int cut;
        int bx;
        int by;
        int bz;
        int k;
        bx = int'($urandom_range(4095)) - 2048;
        by = int'($urandom_range(4095)) - 2048;
        bz = int'($urandom_range(4095)) - 2048;
        cut = broken ? int'($urandom_range(N_CAL, 1)) : -1;
        queue_sample(1'b1, random_axis(bx), random_axis(by), random_axis(bz));
        left = N_CAL;
        while (left > 0) begin
            if (left == cut) begin
                queue_sample(1'b1, random_axis(bx), random_axis(by), random_axis(bz));
                left = N_CAL;
                cut  = -1;
            end else begin
                if (use_fixed) begin
                    queue_sample(1'b0, fixed_word, fixed_word, fixed_word);
                end else begin
                    queue_sample(1'b0, random_axis(bx), random_axis(by), random_axis(bz));
                end
                left--;
            end
        end
        for (k = 0; k < tail; k++) begin
            queue_sample($urandom_range(15) == 0, random_axis(bx), random_axis(by),
                         random_axis(bz));
        end
    endtask

    // Hold until every sample is sent and every reading has come back
    task automatic wait_drained();
        @(negedge i_clk);
        while (sample_queue.size() != 0 || i_valid || pending_readings.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Setup cycle, access cycle; the register takes the write at the access edge
    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_one_g();
        logic [APB_DATA_W-1:0] rd;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ONE_G_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== APB_DATA_W'(one_g_val)) begin
            $display("%0t  one_g readback mismatch: expected %0d, actual %0d",
                     $time, one_g_val, rd);
            mismatch_count++;
        end
    endtask

    task automatic set_one_g(logic [ONE_G_W-1:0] value);
        apb_write(ONE_G_ADDR, APB_DATA_W'(value));
        one_g_val = value;
        settings_used++;
        check_one_g();
    endtask

    task automatic compare_field(string field, int expected_v, int actual_v);
        if (expected_v != actual_v) begin
            $display("%0t  %s mismatch: expected %0d, actual %0d",
                     $time, field, expected_v, actual_v);
            mismatch_count++;
        end
    endtask

    // Driver: present the next sample once the current transaction is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                pending_readings.push_back(calibrate_sample(cur_sample));
                items_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (sample_queue.size() != 0 &&
                    ((items_sent >= 300 && items_sent < 450) || $urandom_range(99) >= 16)) begin
                    cur_sample = sample_queue.pop_front();
                    i_valid <= 1'b1;
                    i_cmd   <= cur_sample.cmd;
                    i_raw_x <= cur_sample.raw_x;
                    i_raw_y <= cur_sample.raw_y;
                    i_raw_z <= cur_sample.raw_z;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted reading and drive the result stall
    always @(posedge i_clk) begin
        reading_t expected_r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (pending_readings.size() == 0) begin
                    $display("%0t  unexpected reading: x=%0d y=%0d z=%0d calibrated=%0d",
                             $time, o_out_x, o_out_y, o_out_z, o_calibrated);
                    mismatch_count++;
                end else begin
                    expected_r = pending_readings.pop_front();
                    if (expected_r.calibrated) calibrated_seen++;
                    compare_field("out_x", int'(expected_r.out_x), int'(o_out_x));
                    compare_field("out_y", int'(expected_r.out_y), int'(o_out_y));
                    compare_field("out_z", int'(expected_r.out_z), int'(o_out_z));
                    compare_field("calibrated", int'(expected_r.calibrated),
                                  int'(o_calibrated));
                end
            end
            // long hold-off so the pipeline fills and stalls its input
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (results_seen >= next_hold_at) begin
                i_stall <= 1'b1;
                hold_left = 59;
                next_hold_at += 400;
            end else begin
                i_stall <= !(results_seen >= 300 && results_seen < 450) &&
                           ($urandom_range(99) < 16);
            end
        end
    end

    // Stimulus
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // never calibrated: offsets zero, extremes of the scaling
        queue_sample(1'b0, 16'h0000, 16'h0000, 16'h0000);
        queue_sample(1'b0, 16'h7FFF, 16'h8000, 16'hFFFF);
        queue_sample(1'b0, 16'hFFF0, 16'hFFF1, 16'h000F);
        queue_sample(1'b0, 16'h0010, 16'h8001, 16'h7FF0);
        queue_sample(1'b0, 16'h5555, 16'hAAAA, 16'h1234);
        queue_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // back-to-back restarts, then a few summed samples
        queue_sample(1'b1, 16'h8000, 16'h7FFF, 16'hFFF1);
        queue_sample(1'b1, 16'hFFFF, 16'h0000, 16'h7FFF);
        queue_sample(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_sample(1'b0, 16'h8000, 16'h8000, 16'h8000);
        queue_sample(1'b0, 16'h0123, 16'hFEDC, 16'h8888);
        wait_drained();

        // write past the register map must leave one_g alone
        apb_write(SPARE_ADDR, '1);
        check_one_g();

        // most negative sums, largest one_g
        set_one_g(11'd2047);
        @(negedge i_clk);
        queue_calibration(16'h8000, 1'b1, 0, 1'b0);
        queue_sample(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_sample(1'b0, 16'h8000, 16'h8000, 16'h8000);
        queue_sample(1'b0, 16'h0000, 16'hFFF8, 16'h0007);
        wait_drained();

        // most positive sums, zero one_g
        set_one_g(11'd0);
        @(negedge i_clk);
        queue_calibration(16'h7FFF, 1'b1, 0, 1'b0);
        queue_sample(1'b0, 16'h8000, 16'h8000, 16'h8000);
        queue_sample(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_sample(1'b0, 16'h0000, 16'hFFF8, 16'h0007);

        // random calibrations, a fresh one_g for each
        while (items_queued < ITEM_TARGET) begin
            wait_drained();
            if ($urandom_range(3) == 0) begin
                set_one_g(ONE_G_RST);
            end else begin
                set_one_g(ONE_G_W'($urandom_range(2047)));
            end
            @(negedge i_clk);
            queue_calibration('0, 1'b0, $urandom_range(60, 10), $urandom_range(4) == 0);
        end
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Checked %0d readings from %0d samples (%0d restarts, %0d corrected).",
                 results_seen, items_sent, restarts_queued, calibrated_seen);
        $display("Used %0d one_g settings; %0d mismatches.", settings_used, mismatch_count);
        if (mismatch_count == 0) begin
            $display("** accel_offset_calibration: PASSED **");
        end else begin
            $display("** accel_offset_calibration: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout with %0d readings still pending.", pending_readings.size());
        $display("** accel_offset_calibration: FAILED **");
        $finish;
    end

endmodule
